[rtl/core/wsls_pkg.sv]
// ----------------------------------------------------------------------------
// wsls_pkg
// shared constants, types and helpers of the word split and length sort block
// ----------------------------------------------------------------------------
package wsls_pkg;

    // store sizing
    localparam int MAX_WORDS    = 32;
    localparam int MAX_WORD_LEN = 8;

    // entry index and word count widths (count must reach MAX_WORDS itself)
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = AW + 1;

    // fixed field widths of the result
    localparam int CHARS_W = 64;
    localparam int LEN_W   = 4;
    localparam int TOTAL_W = 6;

    // output tdata layout, lowest bit first
    localparam int OUT_FIELDS_W = CHARS_W + LEN_W + 1 + TOTAL_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // ascii letter bounds
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5a;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7a;

    // one stored word
    typedef struct packed {
        logic               trunc;
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;
    } t_entry;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                    ((c >= CH_LO_A) && (c <= CH_LO_Z));
    endfunction

endpackage

[rtl/core/word_split_and_length_sort.sv]
// ----------------------------------------------------------------------------
// word_split_and_length_sort
// splits a byte stream into letter words, sorts them by length, streams them
// ----------------------------------------------------------------------------
// slave channel: one text byte per transfer in tdata, tlast on the final byte
//   of a text; bytes are taken one per cycle while the block is loading
// master channel: one transfer per stored word, shortest first, tlast on the
//   final word, tuser low only on the single empty result of a wordless text
// sorting: each finished word is written to the store as its ending byte is
//   taken; after the last byte the sort runs through the single read port,
//   row by row for each row i of n words that has entries to its right; the
//   results then follow one per cycle while the receiver takes them; a text
//   with no words passes its result through the empty state into the output
//   register
// o_s_tready is low from the last byte until the emit state, having loaded the
//   final result, returns to loading (for the empty result, until it loads)
// reset empties the store through the word count and drops any partial word
//   and any result; the store contents themselves are not cleared
// a stalled receiver holds the output register; one more entry waits in the
//   read register and no further read is issued until there is room
// ----------------------------------------------------------------------------
module word_split_and_length_sort (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side: tdata = char_in[7:0]; tlast = last_char
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,
    input  logic                             i_s_tlast,
    // master side: tdata = word_chars[63:0], word_length[67:64],
    // word_truncated[68], total_words[74:69], words_dropped[75], zero pad
    // tuser = word_valid; tlast = last_word
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [wsls_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tuser,
    output logic                             o_m_tlast
);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_RD_I  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_EMPTY = 5'b10000
    } t_state;

    localparam int AW    = wsls_pkg::AW;
    localparam int CW    = wsls_pkg::CW;
    localparam int LEN_W = wsls_pkg::LEN_W;
    localparam int CH_W  = wsls_pkg::CHARS_W;

    // entry store, one synchronous read port with registered data
    wsls_pkg::t_entry r_mem [wsls_pkg::MAX_WORDS];
    wsls_pkg::t_entry r_rd_data;

    t_state              r_state, n_state;
    // word being collected
    logic [CH_W-1:0]     r_word, n_word;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_in_word, n_in_word;
    // store bookkeeping
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovf, n_ovf;
    // sort pass: row i, read pointer j, compare stage
    logic [AW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic                r_first, n_first;
    logic                r_dv, n_dv;
    logic [AW-1:0]       r_dv_addr, n_dv_addr;
    wsls_pkg::t_entry    r_hold, n_hold;
    // emit: read pointer and the entry waiting in the read register
    logic [CW-1:0]       r_k, n_k;
    logic                r_pend, n_pend;
    logic                r_pend_last, n_pend_last;
    // output register
    logic                            r_m_tvalid, n_m_tvalid;
    logic [wsls_pkg::OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic                            r_m_tuser, n_m_tuser;
    logic                            r_m_tlast, n_m_tlast;

    // memory port controls
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    wsls_pkg::t_entry    wr_data;

    logic                s_acc;
    logic                letter;
    logic                out_free;
    logic                load_out;
    logic [CH_W-1:0]     upd_word;
    logic [LEN_W-1:0]    upd_len;

    assign o_s_tready = (r_state == S_LOAD);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign letter     = wsls_pkg::is_letter(i_s_tdata);
    assign out_free   = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

    // word after taking in the current byte as a letter
    always_comb begin
        upd_word = r_word;
        upd_len  = r_len;
        if (!r_in_word) begin
            upd_word = {{(CH_W-8){1'b0}}, i_s_tdata};
            upd_len  = LEN_W'(1);
        end else if (r_len < LEN_W'(wsls_pkg::MAX_WORD_LEN)) begin
            for (int b = 0; b < CH_W / 8; b++) begin
                if (r_len == LEN_W'(b)) begin
                    upd_word[8*b +: 8] = i_s_tdata;
                end
            end
            upd_len = r_len + LEN_W'(1);
        end else begin
            // saturate one past the limit, marks the word as cut
            upd_len = LEN_W'(wsls_pkg::MAX_WORD_LEN + 1);
        end
    end

    always_comb begin
        logic             fin;
        logic [CH_W-1:0]  fin_word;
        logic [LEN_W-1:0] fin_len;
        logic             issue;

        n_state     = r_state;
        n_word      = r_word;
        n_len       = r_len;
        n_in_word   = r_in_word;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_first     = r_first;
        n_dv        = r_dv;
        n_dv_addr   = r_dv_addr;
        n_hold      = r_hold;
        n_k         = r_k;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_m_tvalid  = r_m_tvalid && !i_m_tready;
        n_m_tdata   = r_m_tdata;
        n_m_tuser   = r_m_tuser;
        n_m_tlast   = r_m_tlast;

        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_hold;
        load_out = 1'b0;
        issue    = 1'b0;

        // a separator ends the open word; a letter with tlast ends the grown one
        fin      = s_acc && ((letter && i_s_tlast) || (!letter && r_in_word));
        fin_word = letter ? upd_word : r_word;
        fin_len  = letter ? upd_len  : r_len;

        unique case (r_state)
            S_LOAD: begin
                if (s_acc) begin
                    if (letter) begin
                        n_word    = upd_word;
                        n_len     = upd_len;
                        n_in_word = 1'b1;
                    end
                    if (fin) begin
                        if (r_count < CW'(wsls_pkg::MAX_WORDS)) begin
                            wr_en         = 1'b1;
                            wr_addr       = r_count[AW-1:0];
                            wr_data.chars = fin_word;
                            wr_data.trunc = fin_len > LEN_W'(wsls_pkg::MAX_WORD_LEN);
                            wr_data.len   = wr_data.trunc ?
                                            LEN_W'(wsls_pkg::MAX_WORD_LEN) : fin_len;
                            n_count       = r_count + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_in_word = 1'b0;
                        n_word    = '0;
                        n_len     = '0;
                    end
                    if (i_s_tlast) begin
                        n_i     = '0;
                        n_state = (n_count == '0) ? S_EMPTY : S_RD_I;
                    end
                end
            end

            S_RD_I: begin
                if ((CW'(r_i) + CW'(1)) >= r_count) begin
                    // last row has nothing to its right
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_i;
                    n_j     = CW'(r_i) + CW'(1);
                    n_first = 1'b1;
                    n_dv    = 1'b0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (r_first) begin
                    n_hold  = r_rd_data;
                    n_first = 1'b0;
                end else if (r_dv && (r_rd_data.len < r_hold.len)) begin
                    // swap: old holder goes to j, entry j becomes holder of row i
                    wr_en   = 1'b1;
                    wr_addr = r_dv_addr;
                    wr_data = r_hold;
                    n_hold  = r_rd_data;
                end
                if (r_j < r_count) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_j[AW-1:0];
                    n_dv      = 1'b1;
                    n_dv_addr = r_j[AW-1:0];
                    n_j       = r_j + CW'(1);
                end else begin
                    n_dv = 1'b0;
                end
                if (!r_first && !r_dv && (r_j >= r_count)) begin
                    // row done: the minimum settles at i
                    wr_en   = 1'b1;
                    wr_addr = r_i;
                    wr_data = r_hold;
                    n_i     = r_i + AW'(1);
                    n_state = S_RD_I;
                end
            end

            S_EMIT: begin
                load_out = r_pend && out_free;
                issue    = (r_k < r_count) && (!r_pend || load_out);
                if (load_out) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {{wsls_pkg::OUT_PAD_W{1'b0}}, r_ovf,
                                  wsls_pkg::TOTAL_W'(r_count), r_rd_data.trunc,
                                  r_rd_data.len, r_rd_data.chars};
                    n_m_tuser  = 1'b1;
                    n_m_tlast  = r_pend_last;
                end
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_k[AW-1:0];
                    n_k         = r_k + CW'(1);
                    n_pend      = 1'b1;
                    n_pend_last = ((r_k + CW'(1)) == r_count);
                end else if (load_out) begin
                    n_pend = 1'b0;
                end
                if ((r_k == r_count) && !r_pend) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end

            S_EMPTY: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {{wsls_pkg::OUT_PAD_W{1'b0}}, r_ovf,
                                  {(wsls_pkg::OUT_FIELDS_W-1){1'b0}}};
                    n_m_tuser  = 1'b0;
                    n_m_tlast  = 1'b1;
                    n_ovf      = 1'b0;
                    n_state    = S_LOAD;
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // entry store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_len       <= '0;
            r_in_word   <= 1'b0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_first     <= 1'b0;
            r_dv        <= 1'b0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_in_word   <= n_in_word;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_i         <= n_i;
            r_j         <= n_j;
            r_first     <= n_first;
            r_dv        <= n_dv;
            r_k         <= n_k;
            r_pend      <= n_pend;
            r_m_tvalid  <= n_m_tvalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_dv_addr   <= n_dv_addr;
        r_hold      <= n_hold;
        r_pend_last <= n_pend_last;
        r_m_tdata   <= n_m_tdata;
        r_m_tuser   <= n_m_tuser;
        r_m_tlast   <= n_m_tlast;
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(wsls_pkg::MAX_WORDS))
        else $error("word count beyond store depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && wr_en |-> rd_addr != wr_addr)
        else $error("read and write of the same entry in one cycle");

    a_scan_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_dv |-> r_dv_addr > r_i)
        else $error("compare stage holds an entry left of the row");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_tlast |=> (r_state == S_RD_I) || (r_state == S_EMPTY))
        else $error("final byte did not start sort or empty result");

    a_pend_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == S_EMIT)
        else $error("entry waiting outside of emit");

endmodule

[sim/word_sort_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// word_sort_checker
// watches both channels of the word split and length sort block, predicts the
// sorted word results of every text and compares each result transfer
// ----------------------------------------------------------------------------
module word_sort_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [7:0]                       i_s_tdata,   // char_in[7:0]
    input  logic                             i_s_tlast,   // last_char
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // word_chars[63:0], word_length[67:64], word_truncated[68],
    // total_words[74:69], words_dropped[75], zero pad
    input  logic [wsls_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_m_tuser,   // word_valid
    input  logic                             i_m_tlast,   // last_word
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_results
);
    import wsls_pkg::*;

    localparam int LEN_LO    = CHARS_W;
    localparam int TRUNC_BIT = CHARS_W + LEN_W;
    localparam int TOTAL_LO  = TRUNC_BIT + 1;
    localparam int DROP_BIT  = TOTAL_LO + TOTAL_W;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        logic               trunc;
        logic               valid;
        logic [TOTAL_W-1:0] total;
        logic               dropped;
        logic               last;
    } word_result_t;

    // predicted word store and the word being collected
    logic [CHARS_W-1:0] store_chars [MAX_WORDS];
    logic [LEN_W-1:0]   store_len   [MAX_WORDS];
    logic               store_trunc [MAX_WORDS];
    logic [CHARS_W-1:0] cur_chars;
    logic [4:0]         cur_len;
    logic               in_word;
    logic [CW-1:0]      word_cnt;
    logic               dropped_flag;

    word_result_t sorted_words[$];

    task automatic clear_text();
        cur_chars    = '0;
        cur_len      = '0;
        in_word      = 1'b0;
        word_cnt     = '0;
        dropped_flag = 1'b0;
    endtask

    task automatic close_word();
        if (in_word) begin
            if (word_cnt < MAX_WORDS) begin
                store_chars[word_cnt] = cur_chars;
                store_len[word_cnt]   = (cur_len > MAX_WORD_LEN) ? LEN_W'(MAX_WORD_LEN)
                                                                 : LEN_W'(cur_len);
                store_trunc[word_cnt] = (cur_len > MAX_WORD_LEN);
                word_cnt++;
            end else begin
                dropped_flag = 1'b1;
            end
        end
        in_word   = 1'b0;
        cur_chars = '0;
        cur_len   = '0;
    endtask

    // exchange sort by kept length, swap only on strictly shorter
    task automatic sort_and_emit();
        logic [CHARS_W-1:0] t_chars;
        logic [LEN_W-1:0]   t_len;
        logic               t_trunc;
        word_result_t       r;
        for (int i = 0; i < word_cnt; i++) begin
            for (int j = i; j < word_cnt; j++) begin
                if (store_len[j] < store_len[i]) begin
                    t_chars = store_chars[i];
                    t_len   = store_len[i];
                    t_trunc = store_trunc[i];
                    store_chars[i] = store_chars[j];
                    store_len[i]   = store_len[j];
                    store_trunc[i] = store_trunc[j];
                    store_chars[j] = t_chars;
                    store_len[j]   = t_len;
                    store_trunc[j] = t_trunc;
                end
            end
        end
        if (word_cnt == 0) begin
            // text without words gives one empty result
            r         = '0;
            r.dropped = dropped_flag;
            r.last    = 1'b1;
            sorted_words.push_back(r);
        end else begin
            for (int k = 0; k < word_cnt; k++) begin
                r.chars   = store_chars[k];
                r.len     = store_len[k];
                r.trunc   = store_trunc[k];
                r.valid   = 1'b1;
                r.total   = TOTAL_W'(word_cnt);
                r.dropped = dropped_flag;
                r.last    = (k == word_cnt - 1);
                sorted_words.push_back(r);
            end
        end
    endtask

    task automatic take_byte(input logic [7:0] c, input logic lst);
        logic letter;
        letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
        if (letter) begin
            if (!in_word) begin
                in_word   = 1'b1;
                cur_chars = '0;
                cur_len   = '0;
            end
            if (cur_len < MAX_WORD_LEN) begin
                cur_chars[8*cur_len +: 8] = c;
                cur_len++;
            end else begin
                cur_len = 5'(MAX_WORD_LEN + 1);
            end
        end else begin
            close_word();
        end
        if (lst) begin
            close_word();
            sort_and_emit();
            clear_text();
        end
    endtask

    task automatic show(input string tag, input word_result_t r);
        $display("  %s chars=%h len=%0d trunc=%0b valid=%0b total=%0d dropped=%0b last=%0b",
                 tag, r.chars, r.len, r.trunc, r.valid, r.total, r.dropped, r.last);
    endtask

    always @(posedge i_clk) begin : monitor
        word_result_t got;
        word_result_t want;
        if (!i_rst_n) begin
            clear_text();
            sorted_words.delete();
            o_mismatches <= 0;
            o_results    <= 0;
            o_pending    <= 0;
        end else begin
            // result transfer first, the byte of the same edge cannot produce it
            if (i_m_tvalid && i_m_tready) begin
                got.chars   = i_m_tdata[CHARS_W-1:0];
                got.len     = i_m_tdata[LEN_LO +: LEN_W];
                got.trunc   = i_m_tdata[TRUNC_BIT];
                got.valid   = i_m_tuser;
                got.total   = i_m_tdata[TOTAL_LO +: TOTAL_W];
                got.dropped = i_m_tdata[DROP_BIT];
                got.last    = i_m_tlast;
                o_results <= o_results + 1;
                if (sorted_words.size() == 0) begin
                    if (o_mismatches < REPORT_MAX) begin
                        $display("mismatch at %0t: result transfer with nothing pending", $time);
                        show("actual  ", got);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = sorted_words.pop_front();
                    if (got !== want) begin
                        if (o_mismatches < REPORT_MAX) begin
                            $display("mismatch at %0t:", $time);
                            show("expected", want);
                            show("actual  ", got);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                take_byte(i_s_tdata, i_s_tlast);
            o_pending <= sorted_words.size();
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives text bytes into the word split and length sort block in bursts,
// stalls the result side on changing patterns and gives the final verdict
// ----------------------------------------------------------------------------
module tb;
    import wsls_pkg::*;

    localparam int RANDOM_BYTES = 450;
    localparam int IDLE_LIMIT   = 4000;   // well above a full 32-word sort
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [7:0]             s_tdata  = 8'h00;
    logic                   s_tlast  = 1'b0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int mismatches;
    int pending;
    int results;

    always #5 i_clk = ~i_clk;

    word_split_and_length_sort dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    word_sort_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    // watchdog: cycles without any transfer on either channel
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: a mode is kept for a while, then another is drawn
    rx_mode_e rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_hold  = 0;
    int       rx_phase = 0;
    always @(negedge i_clk) begin : receiver
        logic rdy;
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        rx_phase++;
        if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:     rdy = 1'b1;
                RX_RANDOM:   rdy = ($urandom_range(0, 3) != 0);
                RX_PERIODIC: rdy = ((rx_phase % 7) < 4);
                default: begin
                    if ($urandom_range(0, 19) == 0) begin
                        rx_hold = $urandom_range(1, 24);
                        rdy     = 1'b0;
                    end else begin
                        rdy = 1'b1;
                    end
                end
            endcase
        end
        m_tready <= rdy;
    end

    // byte side
    logic [7:0] text_q[$];
    int burst_left = 0;
    int byte_count = 0;
    int text_count = 0;

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return CH_UP_A + 8'($urandom_range(0, 25));
        return CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    // any byte outside both letter ranges
    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, CH_UP_A - 1));
            1:       return 8'($urandom_range(CH_UP_Z + 1, CH_LO_A - 1));
            default: return 8'($urandom_range(CH_LO_Z + 1, 255));
        endcase
    endfunction

    task automatic add_word(input int n);
        repeat (n) text_q.push_back(rand_letter());
    endtask

    task automatic add_seps(input int n);
        repeat (n) text_q.push_back(rand_sep());
    endtask

    task automatic load_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // one byte transfer, called and left at a falling edge
    task automatic put_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        byte_count++;
        @(negedge i_clk);
    endtask

    // sends the collected text, tlast on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            put_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
        text_count++;
    endtask

    initial begin : stimulus
        int nw;
        int r;
        int overflow_texts;
        int directed_bytes;
        overflow_texts = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single letter, word still open at the last byte
        load_str("A");
        send_text();
        // separator only: no words
        text_q.push_back(8'h00);
        send_text();
        // bytes just outside and at the letter bounds, equal lengths keep order
        load_str("@Z[`z{a");
        send_text();
        // long word cut at the kept length
        load_str("ABCDEFGHI");
        text_q.push_back(8'hff);
        send_text();
        // reverse length order
        load_str("ccc~bb a");
        send_text();
        directed_bytes = byte_count;

        while (byte_count < directed_bytes + RANDOM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 5 && overflow_texts < 2) begin
                // fill the word store, at times running past it
                overflow_texts++;
                nw = $urandom_range(MAX_WORDS, MAX_WORDS + 3);
                repeat (nw) begin
                    add_word($urandom_range(1, 2));
                    add_seps(1);
                end
            end else if (r < 85) begin
                // well formed text with random words
                add_seps($urandom_range(0, 2));
                nw = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
                for (int w = 0; w < nw; w++) begin
                    if ($urandom_range(0, 7) == 0)
                        add_word($urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 6));
                    else
                        add_word($urandom_range(1, MAX_WORD_LEN));
                    if (w < nw - 1 || $urandom_range(0, 1))
                        add_seps($urandom_range(1, 3));
                end
                if (text_q.size() == 0)
                    add_seps(1);
            end else begin
                // raw noise bytes
                repeat ($urandom_range(1, 16))
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            send_text();
        end
        s_tvalid <= 1'b0;

        // let all pending results drain, then a few quiet cycles
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d texts, %0d bytes, %0d full-store texts", text_count, byte_count,
                 overflow_texts);
        $display("run: %0d word results compared, %0d mismatches", results, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
